FILE: rtl/lomb_pkg.sv
// Shared types and constants for the limit order matching book.
// Depends on nothing; used by lomb_front, lomb_engine and the top level.
package lomb_pkg;

  localparam int unsigned ORDER_SLOTS     = 32;
  localparam int unsigned LEVELS_PER_SIDE = 16;
  localparam int unsigned SLOT_W  = $clog2(ORDER_SLOTS);
  localparam int unsigned LVL_W   = $clog2(LEVELS_PER_SIDE);
  localparam int unsigned SCAN_N  = (ORDER_SLOTS > LEVELS_PER_SIDE) ? ORDER_SLOTS
                                                                    : LEVELS_PER_SIDE;
  localparam int unsigned SCAN_W  = $clog2(SCAN_N + 1);
  localparam int unsigned TCNT_W  = $clog2(ORDER_SLOTS + 1);
  localparam int unsigned TOTAL_W = 37;

  localparam logic [1:0] OP_PLACE  = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;

  typedef enum logic [2:0] {
    CL_PLACE   = 3'd0,
    CL_REJECT  = 3'd1,
    CL_CANCEL  = 3'd2,
    CL_MODIFY  = 3'd3,
    CL_UNKNOWN = 3'd4
  } cls_e;

  typedef enum logic [2:0] {
    RK_TRADE    = 3'd0,
    RK_PLACED   = 3'd1,
    RK_REJECTED = 3'd2,
    RK_APPLIED  = 3'd3,
    RK_IGNORED  = 3'd4,
    RK_FULL     = 3'd5
  } kind_e;

  typedef struct packed {
    cls_e        cls;
    logic        buy;
    logic [15:0] client;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] target;
  } cmd_t;

  typedef struct packed {
    kind_e              kind;
    logic [31:0]        taker_order;
    logic [31:0]        maker_order;
    logic [15:0]        taker_client;
    logic [15:0]        maker_client;
    logic [31:0]        fill_price;
    logic [31:0]        fill_qty;
    logic [31:0]        top_bid_price;
    logic [TOTAL_W-1:0] top_bid_total;
    logic [31:0]        top_ask_price;
    logic [TOTAL_W-1:0] top_ask_total;
    logic               last;
  } row_t;

endpackage

FILE: rtl/lomb_front.sv
// Command front end: two-entry queue that classifies each command on entry.
// Depends on lomb_pkg.
module lomb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic              buy_side_i,
  input  logic [15:0]       client_i,
  input  logic [31:0]       limit_price_i,
  input  logic [31:0]       quantity_i,
  input  logic [31:0]       target_order_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output lomb_pkg::cmd_t    cmd_o
);

  lomb_pkg::cmd_t q_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;
  lomb_pkg::cmd_t cls_cmd;
  logic           push, pop;

  always_comb begin
    cls_cmd.buy    = buy_side_i;
    cls_cmd.client = client_i;
    cls_cmd.price  = limit_price_i;
    cls_cmd.qty    = quantity_i;
    cls_cmd.target = target_order_i;
    unique case (opcode_i)
      lomb_pkg::OP_PLACE: begin
        cls_cmd.cls = (limit_price_i == 32'd0 || quantity_i == 32'd0) ?
                      lomb_pkg::CL_REJECT : lomb_pkg::CL_PLACE;
      end
      lomb_pkg::OP_CANCEL: cls_cmd.cls = lomb_pkg::CL_CANCEL;
      lomb_pkg::OP_MODIFY: cls_cmd.cls = lomb_pkg::CL_MODIFY;
      default:             cls_cmd.cls = lomb_pkg::CL_UNKNOWN;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rptr_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = cmd_valid_o & cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wptr_q] <= cls_cmd;
  end

endmodule

FILE: rtl/lomb_engine.sv
// Matching engine: order table, price levels, trade buffer and result register.
// Depends on lomb_pkg; fed by lomb_front.
module lomb_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  lomb_pkg::cmd_t cmd_i,
  output logic           row_valid_o,
  input  logic           row_ready_i,
  output lomb_pkg::row_t row_o
);

  localparam int unsigned SW = lomb_pkg::SLOT_W;
  localparam int unsigned LW = lomb_pkg::LVL_W;
  localparam int unsigned CW = lomb_pkg::SCAN_W;
  localparam int unsigned TW = lomb_pkg::TCNT_W;
  localparam int unsigned NS = lomb_pkg::ORDER_SLOTS;
  localparam int unsigned NL = lomb_pkg::LEVELS_PER_SIDE;
  localparam int unsigned XW = lomb_pkg::TOTAL_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LVL  = 4'd1;
  localparam logic [3:0] S_SLOT = 4'd2;
  localparam logic [3:0] S_FILL = 4'd3;
  localparam logic [3:0] S_REST = 4'd4;
  localparam logic [3:0] S_FIND = 4'd5;
  localparam logic [3:0] S_CLVL = 4'd6;
  localparam logic [3:0] S_TOP  = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  // book storage
  logic        slot_used_q   [NS];
  logic [31:0] slot_number_q [NS];
  logic [15:0] slot_client_q [NS];
  logic        slot_is_buy_q [NS];
  logic [31:0] slot_price_q  [NS];
  logic [31:0] slot_rem_q    [NS];
  logic [31:0] slot_arr_q    [NS];
  logic          lv_used_q  [2][NL];
  logic [31:0]   lv_price_q [2][NL];
  logic [XW-1:0] lv_total_q [2][NL];

  // trade buffer
  logic [31:0] tb_num_q   [NS];
  logic [15:0] tb_cli_q   [NS];
  logic [31:0] tb_price_q [NS];
  logic [31:0] tb_qty_q   [NS];

  logic [3:0]  state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  lomb_pkg::cls_e  cls_q, cls_d;
  lomb_pkg::kind_e kind_q, kind_d;
  logic        buy_q, buy_d, side_q, side_d;
  logic [15:0] client_q, client_d;
  logic [31:0] price_q, price_d, qty_q, qty_d, rem_q, rem_d;
  logic [31:0] fin_taker_q, fin_taker_d;
  logic [15:0] fin_tcli_q, fin_tcli_d;
  logic [31:0] next_num_q, next_num_d, next_arr_q, next_arr_d;
  logic        found_q, found_d, lvf_q, lvf_d, lf_q, lf_d;
  logic [SW-1:0] bidx_q, bidx_d;
  logic [31:0] bage_q, bage_d, bnum_q, bnum_d, brem_q, brem_d;
  logic [15:0] bcli_q, bcli_d;
  logic [LW-1:0] lv_q, lv_d, lfree_q, lfree_d;
  logic [31:0] lp_q, lp_d;
  logic [XW-1:0] lt_q, lt_d;
  logic [TW-1:0] ntr_q, ntr_d, ecnt_q, ecnt_d;
  logic        bf_q, bf_d, af_q, af_d;
  logic [31:0] bp_q, bp_d, ap_q, ap_d;
  logic [XW-1:0] bt_q, bt_d, at_q, at_d;
  logic        row_valid_q, row_valid_d;
  lomb_pkg::row_t row_q, row_d;

  // write controls
  logic        su_we, su_val, sf_we, sr_we, tb_we;
  logic [SW-1:0] sw_idx;
  logic [31:0] sr_val;
  logic        lu_we, lu_val, lpw_we, ltw_we, lw_side;
  logic [LW-1:0] lw_idx;
  logic [XW-1:0] ltw_val;
  logic [31:0] fill_t;

  logic [SW-1:0] si;
  logic [LW-1:0] li;
  logic        in_slots, in_lvls;
  logic [31:0] age, nq;
  logic        emit_last;

  assign si       = cnt_q[SW-1:0];
  assign li       = cnt_q[LW-1:0];
  assign in_slots = cnt_q < CW'(NS);
  assign in_lvls  = cnt_q < CW'(NL);
  assign age      = next_arr_q - slot_arr_q[si];
  assign nq       = (cls_q == lomb_pkg::CL_MODIFY) ? qty_q : 32'd0;
  assign fill_t   = (rem_q < brem_q) ? rem_q : brem_q;
  assign emit_last = (ecnt_q == ntr_q);

  assign cmd_ready_o = (state_q == S_IDLE);
  assign row_valid_o = row_valid_q;
  assign row_o       = row_q;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; cls_d = cls_q; kind_d = kind_q;
    buy_d = buy_q; side_d = side_q; client_d = client_q; price_d = price_q;
    qty_d = qty_q; rem_d = rem_q; fin_taker_d = fin_taker_q; fin_tcli_d = fin_tcli_q;
    next_num_d = next_num_q; next_arr_d = next_arr_q;
    found_d = found_q; lvf_d = lvf_q; lf_d = lf_q; bidx_d = bidx_q; bage_d = bage_q;
    bnum_d = bnum_q; brem_d = brem_q; bcli_d = bcli_q; lv_d = lv_q; lfree_d = lfree_q;
    lp_d = lp_q; lt_d = lt_q; ntr_d = ntr_q; ecnt_d = ecnt_q;
    bf_d = bf_q; af_d = af_q; bp_d = bp_q; ap_d = ap_q; bt_d = bt_q; at_d = at_q;
    row_valid_d = row_valid_q & ~row_ready_i;
    row_d = row_q;
    su_we = 1'b0; su_val = 1'b0; sf_we = 1'b0; sr_we = 1'b0; tb_we = 1'b0;
    sw_idx = bidx_q; sr_val = 32'd0;
    lu_we = 1'b0; lu_val = 1'b0; lpw_we = 1'b0; ltw_we = 1'b0;
    lw_side = side_q; lw_idx = lv_q; ltw_val = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cls_d = cmd_i.cls; buy_d = cmd_i.buy; client_d = cmd_i.client;
          price_d = cmd_i.price; qty_d = cmd_i.qty;
          ntr_d = '0; cnt_d = '0; found_d = 1'b0; lvf_d = 1'b0; lf_d = 1'b0;
          fin_taker_d = 32'd0; fin_tcli_d = 16'd0; rem_d = 32'd0;
          bf_d = 1'b0; af_d = 1'b0; bp_d = 32'd0; ap_d = 32'd0; bt_d = '0; at_d = '0;
          unique case (cmd_i.cls)
            lomb_pkg::CL_PLACE: begin
              fin_taker_d = next_num_q; fin_tcli_d = cmd_i.client;
              next_num_d = next_num_q + 32'd1;
              rem_d = cmd_i.qty; side_d = ~cmd_i.buy;
              state_d = S_LVL;
            end
            lomb_pkg::CL_CANCEL, lomb_pkg::CL_MODIFY: begin
              fin_taker_d = cmd_i.target;
              state_d = S_FIND;
            end
            lomb_pkg::CL_REJECT: begin
              kind_d = lomb_pkg::RK_REJECTED; state_d = S_TOP;
            end
            default: begin
              kind_d = lomb_pkg::RK_IGNORED; state_d = S_TOP;
            end
          endcase
        end
      end

      S_LVL: begin
        if (in_lvls) begin
          cnt_d = cnt_q + CW'(1);
          if (lv_used_q[side_q][li] && (!found_q ||
              (side_q ? (lv_price_q[side_q][li] > lp_q) : (lv_price_q[side_q][li] < lp_q))))
          begin
            found_d = 1'b1; lv_d = li; lp_d = lv_price_q[side_q][li];
            lt_d = lv_total_q[side_q][li];
          end
        end else begin
          cnt_d = '0; found_d = 1'b0;
          if (!found_q || (buy_q ? (lp_q > price_q) : (lp_q < price_q))) begin
            side_d = buy_q; state_d = S_REST;
          end else begin
            state_d = S_SLOT;
          end
        end
      end

      S_SLOT: begin
        if (in_slots) begin
          cnt_d = cnt_q + CW'(1);
          if (slot_used_q[si] && slot_is_buy_q[si] == side_q && slot_price_q[si] == lp_q &&
              (!found_q || age > bage_q)) begin
            found_d = 1'b1; bidx_d = si; bage_d = age; bnum_d = slot_number_q[si];
            bcli_d = slot_client_q[si]; brem_d = slot_rem_q[si];
          end
        end else begin
          cnt_d = '0; found_d = 1'b0;
          if (!found_q) begin
            lu_we = 1'b1; lu_val = 1'b0;
            if (rem_q != 32'd0) begin
              state_d = S_LVL;
            end else begin
              side_d = buy_q; state_d = S_REST;
            end
          end else if (rem_q == 32'd0) begin
            side_d = buy_q; state_d = S_REST;
          end else begin
            state_d = S_FILL;
          end
        end
      end

      S_FILL: begin
        state_d = S_SLOT;
        if (brem_q == 32'd0) begin
          su_we = 1'b1; su_val = 1'b0;
        end else begin
          tb_we = 1'b1;
          ntr_d = ntr_q + TW'(1);
          rem_d = rem_q - fill_t;
          sr_we = 1'b1; sr_val = brem_q - fill_t;
          if (brem_q == fill_t) begin
            su_we = 1'b1; su_val = 1'b0;
          end
          lt_d = lt_q - XW'(fill_t);
          ltw_we = 1'b1; ltw_val = lt_q - XW'(fill_t);
        end
      end

      S_REST: begin
        if (rem_q == 32'd0) begin
          kind_d = lomb_pkg::RK_PLACED; state_d = S_TOP;
        end else if (cnt_q < CW'(lomb_pkg::SCAN_N)) begin
          cnt_d = cnt_q + CW'(1);
          if (in_slots && !slot_used_q[si] && !found_q) begin
            found_d = 1'b1; bidx_d = si;
          end
          if (in_lvls) begin
            if (lv_used_q[side_q][li] && lv_price_q[side_q][li] == price_q && !lvf_q) begin
              lvf_d = 1'b1; lv_d = li; lt_d = lv_total_q[side_q][li];
            end
            if (!lv_used_q[side_q][li] && !lf_q) begin
              lf_d = 1'b1; lfree_d = li;
            end
          end
        end else begin
          cnt_d = '0; found_d = 1'b0; lvf_d = 1'b0; lf_d = 1'b0;
          state_d = S_TOP;
          if (!found_q || (!lvf_q && !lf_q)) begin
            kind_d = lomb_pkg::RK_FULL;
          end else begin
            kind_d = lomb_pkg::RK_PLACED;
            sf_we = 1'b1; su_we = 1'b1; su_val = 1'b1;
            sr_we = 1'b1; sr_val = rem_q;
            next_arr_d = next_arr_q + 32'd1;
            ltw_we = 1'b1;
            if (lvf_q) begin
              ltw_val = lt_q + XW'(rem_q);
            end else begin
              lw_idx = lfree_q; lu_we = 1'b1; lu_val = 1'b1; lpw_we = 1'b1;
              ltw_val = XW'(rem_q);
            end
          end
        end
      end

      S_FIND: begin
        if (in_slots) begin
          cnt_d = cnt_q + CW'(1);
          if (!found_q && slot_used_q[si] && slot_number_q[si] == fin_taker_q) begin
            found_d = 1'b1; bidx_d = si; brem_d = slot_rem_q[si];
            side_d = slot_is_buy_q[si]; lp_d = slot_price_q[si];
          end
        end else begin
          cnt_d = '0; found_d = 1'b0;
          if (!found_q || brem_q == 32'd0 || nq == brem_q) begin
            kind_d = lomb_pkg::RK_IGNORED; state_d = S_TOP;
          end else begin
            state_d = S_CLVL;
          end
        end
      end

      S_CLVL: begin
        if (in_lvls) begin
          cnt_d = cnt_q + CW'(1);
          if (!lvf_q && lv_used_q[side_q][li] && lv_price_q[side_q][li] == lp_q) begin
            lvf_d = 1'b1; lv_d = li; lt_d = lv_total_q[side_q][li];
          end
        end else begin
          cnt_d = '0; lvf_d = 1'b0; state_d = S_TOP;
          if (!lvf_q) begin
            kind_d = lomb_pkg::RK_IGNORED;
          end else begin
            kind_d = lomb_pkg::RK_APPLIED;
            sr_we = 1'b1; sr_val = nq;
            ltw_we = 1'b1;
            ltw_val = (nq > brem_q) ? lt_q + XW'(nq - brem_q) : lt_q - XW'(brem_q - nq);
          end
        end
      end

      S_TOP: begin
        if (in_lvls) begin
          cnt_d = cnt_q + CW'(1);
          if (lv_used_q[1][li] && (!bf_q || lv_price_q[1][li] > bp_q)) begin
            bf_d = 1'b1; bp_d = lv_price_q[1][li]; bt_d = lv_total_q[1][li];
          end
          if (lv_used_q[0][li] && (!af_q || lv_price_q[0][li] < ap_q)) begin
            af_d = 1'b1; ap_d = lv_price_q[0][li]; at_d = lv_total_q[0][li];
          end
        end else begin
          cnt_d = '0; ecnt_d = '0; state_d = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!row_valid_q || row_ready_i) begin
          row_valid_d = 1'b1;
          row_d.taker_order   = fin_taker_q;
          row_d.taker_client  = fin_tcli_q;
          row_d.top_bid_price = bp_q;
          row_d.top_bid_total = bt_q;
          row_d.top_ask_price = ap_q;
          row_d.top_ask_total = at_q;
          row_d.last          = emit_last;
          if (emit_last) begin
            row_d.kind         = kind_q;
            row_d.maker_order  = 32'd0;
            row_d.maker_client = 16'd0;
            row_d.fill_price   = 32'd0;
            row_d.fill_qty     = (cls_q == lomb_pkg::CL_PLACE) ? rem_q : 32'd0;
            state_d = S_IDLE;
          end else begin
            row_d.kind         = lomb_pkg::RK_TRADE;
            row_d.maker_order  = tb_num_q[ecnt_q[SW-1:0]];
            row_d.maker_client = tb_cli_q[ecnt_q[SW-1:0]];
            row_d.fill_price   = tb_price_q[ecnt_q[SW-1:0]];
            row_d.fill_qty     = tb_qty_q[ecnt_q[SW-1:0]];
            ecnt_d = ecnt_q + TW'(1);
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      next_num_q  <= 32'd1;
      next_arr_q  <= 32'd0;
      row_valid_q <= 1'b0;
      cnt_q       <= '0;
      ntr_q       <= '0;
      ecnt_q      <= '0;
      found_q     <= 1'b0;
      lvf_q       <= 1'b0;
      lf_q        <= 1'b0;
      bf_q        <= 1'b0;
      af_q        <= 1'b0;
      for (int i = 0; i < NS; i++) slot_used_q[i] <= 1'b0;
      for (int i = 0; i < NL; i++) begin
        lv_used_q[0][i] <= 1'b0;
        lv_used_q[1][i] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      next_num_q  <= next_num_d;
      next_arr_q  <= next_arr_d;
      row_valid_q <= row_valid_d;
      cnt_q       <= cnt_d;
      ntr_q       <= ntr_d;
      ecnt_q      <= ecnt_d;
      found_q     <= found_d;
      lvf_q       <= lvf_d;
      lf_q        <= lf_d;
      bf_q        <= bf_d;
      af_q        <= af_d;
      if (su_we) slot_used_q[sw_idx] <= su_val;
      if (lu_we) lv_used_q[lw_side][lw_idx] <= lu_val;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d; kind_q <= kind_d; buy_q <= buy_d; side_q <= side_d;
    client_q <= client_d; price_q <= price_d; qty_q <= qty_d; rem_q <= rem_d;
    fin_taker_q <= fin_taker_d; fin_tcli_q <= fin_tcli_d;
    bidx_q <= bidx_d; bage_q <= bage_d; bnum_q <= bnum_d; brem_q <= brem_d;
    bcli_q <= bcli_d; lv_q <= lv_d; lfree_q <= lfree_d; lp_q <= lp_d; lt_q <= lt_d;
    bp_q <= bp_d; ap_q <= ap_d; bt_q <= bt_d; at_q <= at_d;
    row_q <= row_d;
    if (sf_we) begin
      slot_number_q[sw_idx] <= fin_taker_q;
      slot_client_q[sw_idx] <= client_q;
      slot_is_buy_q[sw_idx] <= buy_q;
      slot_price_q[sw_idx]  <= price_q;
      slot_arr_q[sw_idx]    <= next_arr_q;
    end
    if (sr_we) slot_rem_q[sw_idx] <= sr_val;
    if (lpw_we) lv_price_q[lw_side][lw_idx] <= price_q;
    if (ltw_we) lv_total_q[lw_side][lw_idx] <= ltw_val;
    if (tb_we) begin
      tb_num_q[ntr_q[SW-1:0]]   <= bnum_q;
      tb_cli_q[ntr_q[SW-1:0]]   <= bcli_q;
      tb_price_q[ntr_q[SW-1:0]] <= lp_q;
      tb_qty_q[ntr_q[SW-1:0]]   <= fill_t;
    end
  end

  a_trade_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ntr_q <= TW'(NS))
    else $error("trade buffer overrun");

  a_fill_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL |-> rem_q != 32'd0)
    else $error("fill entered with nothing left to trade");

  a_trade_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL && brem_q != 32'd0) |=> ntr_q == $past(ntr_q) + TW'(1))
    else $error("fill did not log a trade");

  a_num_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && cmd_valid_i && cmd_i.cls == lomb_pkg::CL_PLACE)
      |=> next_num_q == $past(next_num_q) + 32'd1)
    else $error("order number not advanced on place");

endmodule

FILE: rtl/limit_order_matching_book.sv
// Top level of the limit order matching book: command front end and engine.
// Depends on lomb_pkg, lomb_front and lomb_engine.
//
//   channel  handshake                 payload
//   in       in_valid_i / in_ready_o   opcode_i .. target_order_i
//   out      out_valid_o / out_ready_i result_kind_o .. last_result_o
//
// A command is registered in the queue and enters the engine only when it is idle. Each
// level or order search is a sequential scan plus a decision. A place runs a level search
// per level, an order search and a fill per fill or dropped stale order, an order search
// to close each level and a scan to rest a remainder; cancel and modify run an order
// search and a level search, or stop after the order search when ignored early. The
// top-of-book scan and result rows follow. Reset empties the book at once. The two-entry
// queue takes commands until full while the engine works or waits on a stalled output.
module limit_order_matching_book (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic        buy_side_i,
  input  logic [15:0] client_i,
  input  logic [31:0] limit_price_i,
  input  logic [31:0] quantity_i,
  input  logic [31:0] target_order_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [31:0] taker_order_o,
  output logic [31:0] maker_order_o,
  output logic [15:0] taker_client_o,
  output logic [15:0] maker_client_o,
  output logic [31:0] fill_price_o,
  output logic [31:0] fill_qty_o,
  output logic [31:0] top_bid_price_o,
  output logic [36:0] top_bid_total_o,
  output logic [31:0] top_ask_price_o,
  output logic [36:0] top_ask_total_o,
  output logic        last_result_o
);

  logic           cmd_valid, cmd_ready;
  lomb_pkg::cmd_t cmd;
  lomb_pkg::row_t row;

  lomb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .buy_side_i     (buy_side_i),
    .client_i       (client_i),
    .limit_price_i  (limit_price_i),
    .quantity_i     (quantity_i),
    .target_order_i (target_order_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_o          (cmd)
  );

  lomb_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .row_valid_o (out_valid_o),
    .row_ready_i (out_ready_i),
    .row_o       (row)
  );

  assign result_kind_o   = row.kind;
  assign taker_order_o   = row.taker_order;
  assign maker_order_o   = row.maker_order;
  assign taker_client_o  = row.taker_client;
  assign maker_client_o  = row.maker_client;
  assign fill_price_o    = row.fill_price;
  assign fill_qty_o      = row.fill_qty;
  assign top_bid_price_o = row.top_bid_price;
  assign top_bid_total_o = row.top_bid_total;
  assign top_ask_price_o = row.top_ask_price;
  assign top_ask_total_o = row.top_ask_total;
  assign last_result_o   = row.last;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for limit_order_matching_book.
// Holds its own price-time priority book that predicts every result row.
// Depends on lomb_pkg and the RTL top level.
module testbench;

  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [1:0]  op;
    logic        buy;
    logic [15:0] client;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] target;
    bit          drain;
  } tb_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = lomb_pkg::OP_PLACE;
  logic        buy_side_i = 1'b0;
  logic [15:0] client_i = '0;
  logic [31:0] limit_price_i = '0;
  logic [31:0] quantity_i = '0;
  logic [31:0] target_order_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  result_kind_o;
  logic [31:0] taker_order_o;
  logic [31:0] maker_order_o;
  logic [15:0] taker_client_o;
  logic [15:0] maker_client_o;
  logic [31:0] fill_price_o;
  logic [31:0] fill_qty_o;
  logic [31:0] top_bid_price_o;
  logic [36:0] top_bid_total_o;
  logic [31:0] top_ask_price_o;
  logic [36:0] top_ask_total_o;
  logic        last_result_o;

  limit_order_matching_book dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // book state
  bit          s_used [lomb_pkg::ORDER_SLOTS];
  logic [31:0] s_num  [lomb_pkg::ORDER_SLOTS];
  logic [15:0] s_cli  [lomb_pkg::ORDER_SLOTS];
  bit          s_buy  [lomb_pkg::ORDER_SLOTS];
  logic [31:0] s_px   [lomb_pkg::ORDER_SLOTS];
  logic [31:0] s_rem  [lomb_pkg::ORDER_SLOTS];
  logic [31:0] s_arr  [lomb_pkg::ORDER_SLOTS];
  bit           lv_used  [2][lomb_pkg::LEVELS_PER_SIDE];
  logic [31:0]  lv_px    [2][lomb_pkg::LEVELS_PER_SIDE];
  logic [36:0]  lv_total [2][lomb_pkg::LEVELS_PER_SIDE];
  logic [31:0] next_num = 32'd1;
  logic [31:0] next_arr = 32'd0;

  lomb_pkg::row_t due_rows[$];
  tb_cmd_t        pending[$];
  int    errors = 0;
  int    accepted = 0;

  function automatic int best_level(bit buy);
    int b = -1;
    for (int i = 0; i < lomb_pkg::LEVELS_PER_SIDE; i++)
      if (lv_used[buy][i] && (b < 0 ||
          (buy ? lv_px[buy][i] > lv_px[buy][b] : lv_px[buy][i] < lv_px[buy][b])))
        b = i;
    return b;
  endfunction

  function automatic int find_level(bit buy, logic [31:0] px);
    for (int i = 0; i < lomb_pkg::LEVELS_PER_SIDE; i++)
      if (lv_used[buy][i] && lv_px[buy][i] == px) return i;
    return -1;
  endfunction

  function automatic int oldest_slot(bit buy, logic [31:0] px);
    int b = -1;
    logic [31:0] age, best_age;
    best_age = '0;
    for (int i = 0; i < lomb_pkg::ORDER_SLOTS; i++) begin
      if (!s_used[i] || s_buy[i] != buy || s_px[i] != px) continue;
      age = next_arr - s_arr[i];
      if (b < 0 || age > best_age) begin
        b = i;
        best_age = age;
      end
    end
    return b;
  endfunction

  function automatic lomb_pkg::row_t mk_row(lomb_pkg::kind_e k, logic [31:0] tk,
                                            logic [31:0] mk, logic [15:0] tc,
                                            logic [15:0] mc, logic [31:0] px,
                                            logic [31:0] q, bit last);
    lomb_pkg::row_t r;
    r = '0;
    r.kind = k;
    r.taker_order = tk;
    r.maker_order = mk;
    r.taker_client = tc;
    r.maker_client = mc;
    r.fill_price = px;
    r.fill_qty = q;
    r.last = last;
    return r;
  endfunction

  task automatic book_apply(tb_cmd_t c);
    lomb_pkg::row_t rows[$];
    lomb_pkg::row_t r;
    logic [31:0] id, rem, lp, t, nq;
    bit opp, fresh;
    int lv, s, bb, ba;
    lomb_pkg::kind_e k;
    if (c.op == lomb_pkg::OP_PLACE) begin
      if (c.price == 0 || c.qty == 0) begin
        rows = {rows, mk_row(lomb_pkg::RK_REJECTED, 0, 0, 0, 0, 0, 0, 1)};
      end else begin
        id = next_num;
        next_num = id + 1;
        rem = c.qty;
        opp = !c.buy;
        while (rem > 0) begin
          lv = best_level(opp);
          if (lv < 0) break;
          lp = lv_px[opp][lv];
          if (c.buy ? lp > c.price : lp < c.price) break;
          while (rem > 0) begin
            s = oldest_slot(opp, lp);
            if (s < 0) break;
            if (s_rem[s] == 0) begin
              s_used[s] = 0;
              continue;
            end
            t = rem < s_rem[s] ? rem : s_rem[s];
            rows = {rows, mk_row(lomb_pkg::RK_TRADE, id, s_num[s], c.client, s_cli[s],
                                 lp, t, 0)};
            rem -= t;
            s_rem[s] -= t;
            lv_total[opp][lv] -= 37'(t);
            if (s_rem[s] == 0) s_used[s] = 0;
          end
          if (oldest_slot(opp, lp) < 0) lv_used[opp][lv] = 0;
        end
        k = lomb_pkg::RK_PLACED;
        if (rem > 0) begin
          s = -1;
          lv = find_level(c.buy, c.price);
          fresh = 0;
          for (int i = 0; i < lomb_pkg::ORDER_SLOTS && s < 0; i++) if (!s_used[i]) s = i;
          if (lv < 0) begin
            fresh = 1;
            for (int i = 0; i < lomb_pkg::LEVELS_PER_SIDE && lv < 0; i++)
              if (!lv_used[c.buy][i]) lv = i;
          end
          if (s < 0 || lv < 0) begin
            k = lomb_pkg::RK_FULL;
          end else begin
            s_used[s] = 1;
            s_num[s] = id;
            s_cli[s] = c.client;
            s_buy[s] = c.buy;
            s_px[s] = c.price;
            s_rem[s] = rem;
            s_arr[s] = next_arr;
            next_arr++;
            if (fresh) begin
              lv_used[c.buy][lv] = 1;
              lv_px[c.buy][lv] = c.price;
              lv_total[c.buy][lv] = '0;
            end
            lv_total[c.buy][lv] += 37'(rem);
          end
        end
        rows = {rows, mk_row(k, id, 0, c.client, 0, 0, rem, 1)};
      end
    end else if (c.op == lomb_pkg::OP_CANCEL || c.op == lomb_pkg::OP_MODIFY) begin
      k = lomb_pkg::RK_IGNORED;
      s = -1;
      for (int i = 0; i < lomb_pkg::ORDER_SLOTS && s < 0; i++)
        if (s_used[i] && s_num[i] == c.target) s = i;
      nq = (c.op == lomb_pkg::OP_MODIFY) ? c.qty : 32'd0;
      if (s >= 0 && s_rem[s] != 0 && nq != s_rem[s]) begin
        lv = find_level(s_buy[s], s_px[s]);
        if (lv >= 0) begin
          if (nq > s_rem[s]) lv_total[s_buy[s]][lv] += 37'(nq - s_rem[s]);
          else lv_total[s_buy[s]][lv] -= 37'(s_rem[s] - nq);
          s_rem[s] = nq;
          k = lomb_pkg::RK_APPLIED;
        end
      end
      rows = {rows, mk_row(k, c.target, 0, 0, 0, 0, 0, 1)};
    end else begin
      rows = {rows, mk_row(lomb_pkg::RK_IGNORED, 0, 0, 0, 0, 0, 0, 1)};
    end
    bb = best_level(1);
    ba = best_level(0);
    foreach (rows[i]) begin
      r = rows[i];
      r.top_bid_price = bb < 0 ? '0 : lv_px[1][bb];
      r.top_bid_total = bb < 0 ? '0 : lv_total[1][bb];
      r.top_ask_price = ba < 0 ? '0 : lv_px[0][ba];
      r.top_ask_total = ba < 0 ? '0 : lv_total[0][ba];
      due_rows = {due_rows, r};
    end
  endtask

  // stimulus generation
  logic [31:0] gen_num = 32'd1;

  task automatic add(logic [1:0] op, logic buy, logic [15:0] cli, logic [31:0] px,
                     logic [31:0] q, logic [31:0] tgt, bit drain = 0);
    tb_cmd_t c;
    c = '{op, buy, cli, px, q, tgt, drain};
    pending = {pending, c};
    if (op == lomb_pkg::OP_PLACE && px != 0 && q != 0) gen_num++;
  endtask

  task automatic add_sweep();
    add(lomb_pkg::OP_PLACE, 1, 16'($urandom), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    add(lomb_pkg::OP_CANCEL, 0, 0, 0, 0, gen_num - 1);
    add(lomb_pkg::OP_PLACE, 0, 16'($urandom), 32'd1, 32'hFFFF_FFFF, 0);
    add(lomb_pkg::OP_CANCEL, 0, 0, 0, 0, gen_num - 1);
  endtask

  task automatic fill_stimulus();
    logic buy;
    logic [31:0] base;
    int k;
    // directed
    add(lomb_pkg::OP_PLACE, 1, 16'h1234, 32'd0, 32'd5, 0);
    add(lomb_pkg::OP_PLACE, 0, 16'h1234, 32'd100, 32'd0, 0);
    add(2'd3, 1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add(lomb_pkg::OP_CANCEL, 0, 0, 0, 0, 32'd999);
    add(lomb_pkg::OP_PLACE, 0, 16'hFFFF, 32'd100, 32'd10, 0);
    add(lomb_pkg::OP_PLACE, 0, 16'h0001, 32'd100, 32'd5, 0);
    add(lomb_pkg::OP_PLACE, 0, 16'h0002, 32'd101, 32'd7, 0);
    add(lomb_pkg::OP_MODIFY, 0, 0, 0, 32'd10, 32'd1);
    add(lomb_pkg::OP_MODIFY, 0, 0, 0, 32'd4, 32'd1);
    add(lomb_pkg::OP_CANCEL, 0, 0, 0, 0, 32'd2);
    add(lomb_pkg::OP_CANCEL, 0, 0, 0, 0, 32'd2);
    add(lomb_pkg::OP_MODIFY, 0, 0, 0, 32'd9, 32'd2);
    add(lomb_pkg::OP_PLACE, 1, 16'h0000, 32'd101, 32'd20, 0);
    add(lomb_pkg::OP_MODIFY, 0, 0, 0, 32'd30, 32'd4);
    add(lomb_pkg::OP_MODIFY, 0, 0, 0, 32'd0, 32'd4);
    add(lomb_pkg::OP_PLACE, 1, 16'hAAAA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1);
    add(lomb_pkg::OP_PLACE, 0, 16'h5555, 32'd1, 32'hFFFF_FFFF, 0);
    add_sweep();
    // random
    while (pending.size() < 350) begin
      k = $urandom_range(0, 9);
      if (k <= 5) begin
        for (int i = 0; i < 20; i++) begin
          k = $urandom_range(0, 9);
          buy = 1'($urandom_range(0, 1));
          if (k <= 5)
            add(lomb_pkg::OP_PLACE, buy, 16'($urandom), buy ? $urandom_range(100, 108)
                : $urandom_range(103, 111), $urandom_range(1, 60), 0, i == 0 && k == 0);
          else
            add(k <= 7 ? lomb_pkg::OP_CANCEL : lomb_pkg::OP_MODIFY, 0, 0, 0,
                $urandom_range(0, 60), gen_num - $urandom_range(1, 24));
        end
      end else if (k == 6) begin
        buy = 1'($urandom_range(0, 1));
        base = $urandom_range(200, 260);
        for (int i = 0; i < 18; i++)
          add(lomb_pkg::OP_PLACE, buy, 16'($urandom), base + i, $urandom_range(1, 9), 0,
              i == 0);
        add_sweep();
      end else if (k == 7) begin
        buy = 1'($urandom_range(0, 1));
        for (int i = 0; i < 34; i++)
          add(lomb_pkg::OP_PLACE, buy, 16'($urandom), 32'd400, $urandom_range(1, 5), 0);
        add(lomb_pkg::OP_CANCEL, 0, 0, 0, 0, gen_num - 20);
        add(lomb_pkg::OP_PLACE, !buy, 16'($urandom), 32'd400, 32'd1000, 0);
        add_sweep();
      end else if (k == 8) begin
        for (int i = 0; i < 10; i++)
          add(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 16'($urandom), $urandom,
              $urandom, $urandom);
        add_sweep();
      end else begin
        add_sweep();
      end
    end
  endtask

  // driver
  tb_cmd_t cur;
  int   burst = 0;
  int   gap = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        book_apply(cur);
        accepted++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (gap > 0) begin
          gap--;
          in_valid_i <= 1'b0;
        end else if (pending.size() > 0 && !(pending[0].drain && due_rows.size() != 0)) begin
          cur = pending[0];
          pending.delete(0);
          in_valid_i     <= 1'b1;
          opcode_i       <= cur.op;
          buy_side_i     <= cur.buy;
          client_i       <= cur.client;
          limit_price_i  <= cur.price;
          quantity_i     <= cur.qty;
          target_order_i <= cur.target;
          if (burst > 0) begin
            burst--;
          end else begin
            burst = $urandom_range(0, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver
  int  hold_left = 0;
  bit  held = 0;
  int  mode = 0;
  int  phase = 0;

  always @(posedge clk_i) begin
    logic rdy;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (!held && accepted >= 120) begin
      held = 1;
      hold_left = 700;
      rdy = 1'b0;
    end else begin
      case (mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
    end
    if (++phase == 50) begin
      phase = 0;
      mode = $urandom_range(0, 2);
    end
    out_ready_i <= rdy;
  end

  // monitor
  function automatic void cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    lomb_pkg::row_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_rows.size() == 0) begin
        $error("result_kind: expected none, got %0h", result_kind_o);
        errors++;
      end else begin
        e = due_rows[0];
        due_rows.delete(0);
        cmp_field("result_kind", 64'(e.kind), 64'(result_kind_o));
        cmp_field("taker_order", 64'(e.taker_order), 64'(taker_order_o));
        cmp_field("maker_order", 64'(e.maker_order), 64'(maker_order_o));
        cmp_field("taker_client", 64'(e.taker_client), 64'(taker_client_o));
        cmp_field("maker_client", 64'(e.maker_client), 64'(maker_client_o));
        cmp_field("fill_price", 64'(e.fill_price), 64'(fill_price_o));
        cmp_field("fill_qty", 64'(e.fill_qty), 64'(fill_qty_o));
        cmp_field("top_bid_price", 64'(e.top_bid_price), 64'(top_bid_price_o));
        cmp_field("top_bid_total", 64'(e.top_bid_total), 64'(top_bid_total_o));
        cmp_field("top_ask_price", 64'(e.top_ask_price), 64'(top_ask_price_o));
        cmp_field("top_ask_total", 64'(e.top_ask_total), 64'(top_ask_total_o));
        cmp_field("last_result", 64'(e.last), 64'(last_result_o));
      end
    end
  end

  // watchdog
  int idle = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
    else idle++;
    if (idle >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    fill_stimulus();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (pending.size() != 0 || in_valid_i || due_rows.size() != 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && due_rows.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: limit_order_matching_book.f
rtl/lomb_pkg.sv
rtl/lomb_front.sv
rtl/lomb_engine.sv
rtl/limit_order_matching_book.sv
verif/testbench.sv
